>>> src/dshf_pkg.sv
package dshf_pkg;

  localparam int unsigned FRAME_W = 16;
  localparam int unsigned MOTOR_W = 2;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned IDLE_W = 7;

  localparam logic [SLOT_W-1:0] SLOT_FIRST_BIT = 6'd3;
  localparam logic [SLOT_W-1:0] SLOT_TAIL = 6'd51;
  localparam logic [SLOT_W-1:0] SLOT_LAST = 6'd53;

  localparam logic [1:0] PH_HIGH = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_LOW = 2'd2;

  localparam logic [10:0] CMD_SPIN_FWD = 11'd20;
  localparam logic [10:0] CMD_SPIN_REV = 11'd21;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor;
    logic [FRAME_W-1:0] frame;
  } dshf_entry_t;

endpackage

>>> src/dshf_front.sv
module dshf_front
  import dshf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [IDLE_W-1:0]   cfg_wr_data,
  input  logic                push,
  input  logic [1:0]          motor_index,
  input  logic [9:0]          throttle,
  input  logic                direction,
  input  logic                grounded,
  input  logic                armed,
  input  logic                test_override,
  input  logic                aux_test,
  input  logic                failsafe,
  input  logic [31:0]         now_us,
  output dshf_entry_t         entry
);

  logic [10:0] idle_add_r, idle_add_nxt;
  logic [10:0] mul_k_r, mul_k_nxt;
  logic        last_dir_r, last_dir_nxt;
  logic [13:0] cmd_cnt_r, cmd_cnt_nxt;
  logic [31:0] fs_start_r, fs_start_nxt;

  logic [IDLE_W-1:0] idle_clamp;
  logic [20:0]       prod;
  logic [11:0]       val_sum;
  logic [10:0]       value;
  logic              force_zero;
  logic              fs_cut;
  logic [31:0]       fs_elapsed;
  logic [13:0]       cnt_inc;
  logic [10:0]       frame_value;
  logic              frame_tel;
  logic              frame_blank;
  logic [11:0]       pkt;
  logic [3:0]        csum;

  // idle terms only change on a config write
  assign idle_clamp = (cfg_wr_data > 7'd99) ? 7'd99 : cfg_wr_data;

  always_comb begin
    idle_add_nxt = idle_add_r;
    mul_k_nxt = mul_k_r;
    if (cfg_wr_en) begin
      idle_add_nxt = {4'd0, idle_clamp} * 11'd20;
      mul_k_nxt = 11'd2001 - ({4'd0, idle_clamp} * 11'd20);
    end
  end

  assign prod = {11'd0, throttle} * {10'd0, mul_k_r};
  assign val_sum = 12'd48 + {1'b0, idle_add_r} + {1'b0, prod[20:10]};
  assign value = val_sum[11] ? 11'd2047 : val_sum[10:0];

  assign force_zero = grounded || !armed ||
                      ((test_override || aux_test) && (throttle <= 10'd2));

  assign fs_elapsed = now_us - fs_start_r;

  always_comb begin
    fs_start_nxt = fs_start_r;
    fs_cut = 1'b0;
    if (failsafe && !test_override) begin
      if (fs_start_r == 32'd0) begin
        fs_start_nxt = now_us;
      end else if (fs_elapsed > 32'd4000000) begin
        fs_cut = 1'b1;
      end
    end else begin
      fs_start_nxt = 32'd0;
    end
  end

  assign cnt_inc = (cmd_cnt_r <= 14'd10000) ? cmd_cnt_r + 14'd1 : cmd_cnt_r;

  always_comb begin
    last_dir_nxt = last_dir_r;
    cmd_cnt_nxt = cmd_cnt_r;
    frame_value = (force_zero || fs_cut) ? 11'd0 : value;
    frame_tel = 1'b0;
    frame_blank = 1'b0;
    if (direction != last_dir_r) begin
      cmd_cnt_nxt = cnt_inc;
      if (cnt_inc > 14'd8000 && cnt_inc <= 14'd8060) begin
        frame_value = direction ? CMD_SPIN_REV : CMD_SPIN_FWD;
        frame_tel = 1'b1;
      end else begin
        frame_blank = 1'b1;
      end
      if (cnt_inc == 14'd10001) begin
        cmd_cnt_nxt = 14'd0;
        last_dir_nxt = direction;
      end
    end
  end

  assign pkt = {frame_value, frame_tel};
  assign csum = pkt[3:0] ^ pkt[7:4] ^ pkt[11:8];

  assign entry = '{motor: motor_index, frame: (frame_blank ? 16'd0 : {pkt, csum})};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_add_r <= 11'd0;
      mul_k_r <= 11'd2001;
      last_dir_r <= 1'b0;
      cmd_cnt_r <= 14'd0;
      fs_start_r <= 32'd1;
    end else begin
      idle_add_r <= idle_add_nxt;
      mul_k_r <= mul_k_nxt;
      if (push) begin
        last_dir_r <= last_dir_nxt;
        cmd_cnt_r <= cmd_cnt_nxt;
        fs_start_r <= fs_start_nxt;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_cnt_r <= 14'd10000)
    else $error("command counter out of range");

  a_dir_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && direction != last_dir_r && cnt_inc == 14'd10001) |=>
    (cmd_cnt_r == 14'd0 && last_dir_r == $past(direction)))
    else $error("direction sequence did not complete");

endmodule

>>> src/dshf_queue.sv
module dshf_queue
  import dshf_pkg::*;
#(
  parameter int unsigned QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  dshf_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        nonempty,
  output dshf_entry_t pop_data
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  dshf_entry_t       mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full = (count_r == CNT_W'(QDEPTH));
  assign nonempty = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && !nonempty))
    else $error("queue overflow or underflow");

endmodule

>>> src/dshf_back.sv
module dshf_back
  import dshf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nonempty,
  input  dshf_entry_t        q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [MOTOR_W-1:0] out_motor,
  output logic [FRAME_W-1:0] out_frame_word,
  output logic               out_line_high,
  output logic               out_last_slot
);

  logic               busy_r, busy_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [FRAME_W-1:0] shift_r, shift_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [MOTOR_W-1:0] motor_r, motor_nxt;
  logic               out_take;
  logic               last;

  assign last = (slot_r == SLOT_LAST);
  assign out_take = busy_r && !out_stall;
  assign q_pop = q_nonempty && (!busy_r || (out_take && last));

  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    frame_nxt = frame_r;
    motor_nxt = motor_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      slot_nxt = '0;
      phase_nxt = PH_HIGH;
      shift_nxt = q_data.frame;
      frame_nxt = q_data.frame;
      motor_nxt = q_data.motor;
    end else if (out_take) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        slot_nxt = slot_r + 1'b1;
        if (slot_r >= SLOT_FIRST_BIT) begin
          case (phase_r)
            PH_HIGH: phase_nxt = PH_DATA;
            PH_DATA: phase_nxt = PH_LOW;
            PH_LOW: begin
              phase_nxt = PH_HIGH;
              shift_nxt = {shift_r[FRAME_W-2:0], 1'b0};
            end
            default: phase_nxt = PH_HIGH;
          endcase
        end
      end
    end
  end

  always_comb begin
    out_line_high = 1'b0;
    if (slot_r >= SLOT_FIRST_BIT && slot_r < SLOT_TAIL) begin
      case (phase_r)
        PH_HIGH: out_line_high = 1'b1;
        PH_DATA: out_line_high = shift_r[FRAME_W-1];
        default: out_line_high = 1'b0;
      endcase
    end
  end

  assign out_valid = busy_r;
  assign out_motor = motor_r;
  assign out_frame_word = frame_r;
  assign out_last_slot = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= '0;
      phase_r <= PH_HIGH;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    frame_r <= frame_nxt;
    motor_r <= motor_nxt;
  end

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> slot_r <= SLOT_LAST)
    else $error("slot counter past end of frame");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && last && !q_nonempty) |=> !busy_r)
    else $error("serializer kept running after last slot");

endmodule

>>> src/dshot_throttle_frame_encoder_core.sv
// a request accepted into the queue is registered there, then loaded into the slot serializer
//   once the serializer is idle or taking its last slot, and its first slot shows from there
// the slot serializer sends one line slot per cycle while out_stall is low
// a small queue lets new requests enter while a frame is still being sent
// reset: synchronous active low; idle offset 0, forward direction, counter 0,
//   failsafe start 1, queue empty
module dshot_throttle_frame_encoder_core
  import dshf_pkg::*;
#(
  parameter int unsigned QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_motor_index,
  input  logic [9:0]  in_throttle,
  input  logic        in_direction,
  input  logic        in_grounded,
  input  logic        in_armed,
  input  logic        in_test_override,
  input  logic        in_aux_test,
  input  logic        in_failsafe,
  input  logic [31:0] in_now_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_motor,
  output logic [15:0] out_frame_word,
  output logic        out_line_high,
  output logic        out_last_slot
);

  dshf_entry_t push_entry;
  dshf_entry_t pop_entry;
  logic        q_full;
  logic        q_nonempty;
  logic        q_pop;
  logic        push;

  assign in_stall = q_full;
  assign push = in_valid && !q_full;

  dshf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .push           (push),
    .motor_index    (in_motor_index),
    .throttle       (in_throttle),
    .direction      (in_direction),
    .grounded       (in_grounded),
    .armed          (in_armed),
    .test_override  (in_test_override),
    .aux_test       (in_aux_test),
    .failsafe       (in_failsafe),
    .now_us         (in_now_us),
    .entry          (push_entry)
  );

  dshf_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (pop_entry)
  );

  dshf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (q_nonempty),
    .q_data         (pop_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_motor      (out_motor),
    .out_frame_word (out_frame_word),
    .out_line_high  (out_line_high),
    .out_last_slot  (out_last_slot)
  );

endmodule

>>> test/tb_dshot_throttle_frame_encoder_core.sv
module tb_dshot_throttle_frame_encoder_core
  import dshf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned THR_FLOOR = 48;
  localparam int unsigned THR_SPAN = 2001;
  localparam int unsigned IDLE_STEP = 20;
  localparam int unsigned IDLE_MAX = 99;
  localparam int unsigned VALUE_MAX = 2047;
  localparam int unsigned TEST_THR_MAX = 2;
  localparam logic [31:0] FS_CUTOFF_US = 32'd4000000;
  localparam int unsigned CMD_WINDOW_START = 8000;
  localparam int unsigned CMD_WINDOW_END = 8060;
  localparam int unsigned CMD_LIMIT = 10000;
  localparam int unsigned SLOT_COUNT = 54;
  localparam int unsigned RANDOM_UPDATES = 360;
  localparam int unsigned MAX_PRINTED = 100;

  typedef struct packed {
    logic [1:0]  motor;
    logic [9:0]  throttle;
    logic        direction;
    logic        grounded;
    logic        armed;
    logic        test_override;
    logic        aux_test;
    logic        failsafe;
    logic [31:0] now_us;
  } motor_update_t;

  typedef struct packed {
    logic [1:0]  motor;
    logic [15:0] frame;
    logic        line_high;
    logic        last_slot;
  } line_slot_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_motor_index = '0;
  logic [9:0]  in_throttle = '0;
  logic        in_direction = 1'b0;
  logic        in_grounded = 1'b0;
  logic        in_armed = 1'b0;
  logic        in_test_override = 1'b0;
  logic        in_aux_test = 1'b0;
  logic        in_failsafe = 1'b0;
  logic [31:0] in_now_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_motor;
  logic [15:0] out_frame_word;
  logic        out_line_high;
  logic        out_last_slot;

  int unsigned idle_setting;
  logic        last_dir;
  int unsigned spin_cmd_count;
  logic [31:0] failsafe_t0;
  line_slot_t  slot_expect_q[$];
  int unsigned mismatches = 0;
  bit          idling_on = 1'b1;
  int unsigned hold_left = 0;
  logic [31:0] clock_us = '0;

  dshot_throttle_frame_encoder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_motor_index   (in_motor_index),
    .in_throttle      (in_throttle),
    .in_direction     (in_direction),
    .in_grounded      (in_grounded),
    .in_armed         (in_armed),
    .in_test_override (in_test_override),
    .in_aux_test      (in_aux_test),
    .in_failsafe      (in_failsafe),
    .in_now_us        (in_now_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_motor        (out_motor),
    .out_frame_word   (out_frame_word),
    .out_line_high    (out_line_high),
    .out_last_slot    (out_last_slot)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [15:0] pack_frame(logic [10:0] value, logic tel);
    logic [11:0] pkt;
    logic [3:0]  csum;
    pkt = {value, tel};
    csum = pkt[3:0] ^ pkt[7:4] ^ pkt[11:8];
    return {pkt, csum};
  endfunction

  // throttle mapping, safety cutoffs and the direction command sequence
  function automatic logic [15:0] encode_frame(motor_update_t u);
    int unsigned idle;
    int unsigned value;
    logic [15:0] frame;
    idle = (idle_setting > IDLE_MAX) ? IDLE_MAX : idle_setting;
    value = THR_FLOOR + idle * IDLE_STEP +
            ((int'(u.throttle) * (THR_SPAN - idle * IDLE_STEP)) >> 10);
    if (value > VALUE_MAX) begin
      value = VALUE_MAX;
    end
    if (u.grounded || !u.armed ||
        ((u.test_override || u.aux_test) && u.throttle <= TEST_THR_MAX)) begin
      value = 0;
    end
    if (u.failsafe && !u.test_override) begin
      if (failsafe_t0 == 32'd0) begin
        failsafe_t0 = u.now_us;
      end else if (u.now_us - failsafe_t0 > FS_CUTOFF_US) begin
        value = 0;
      end
    end else begin
      failsafe_t0 = 32'd0;
    end
    if (u.direction == last_dir) begin
      frame = pack_frame(value[10:0], 1'b0);
    end else begin
      if (spin_cmd_count <= CMD_LIMIT) begin
        spin_cmd_count++;
      end
      if (spin_cmd_count > CMD_WINDOW_START && spin_cmd_count <= CMD_WINDOW_END) begin
        frame = pack_frame(u.direction ? CMD_SPIN_REV : CMD_SPIN_FWD, 1'b1);
      end else begin
        frame = 16'h0000;
      end
      if (spin_cmd_count == CMD_LIMIT + 1) begin
        spin_cmd_count = 0;
        last_dir = u.direction;
      end
    end
    return frame;
  endfunction

  function automatic void queue_line_slots(motor_update_t u);
    logic [15:0] frame;
    line_slot_t  ls;
    int unsigned rel;
    frame = encode_frame(u);
    for (int unsigned s = 0; s < SLOT_COUNT; s++) begin
      ls.motor = u.motor;
      ls.frame = frame;
      ls.line_high = 1'b0;
      ls.last_slot = (s == SLOT_LAST);
      if (s >= SLOT_FIRST_BIT && s < SLOT_TAIL) begin
        rel = s - SLOT_FIRST_BIT;
        case (2'(rel % 3))
          PH_HIGH: ls.line_high = 1'b1;
          PH_DATA: ls.line_high = frame[15 - rel / 3];
          default: ls.line_high = 1'b0;
        endcase
      end
      slot_expect_q.push_back(ls);
    end
  endfunction

  function automatic motor_update_t mk_update(logic [1:0] motor, logic [9:0] thr,
                                              logic dir, logic ground, logic armed,
                                              logic tover, logic aux, logic fs,
                                              logic [31:0] now);
    motor_update_t u;
    u = '{motor, thr, dir, ground, armed, tover, aux, fs, now};
    return u;
  endfunction

  function automatic motor_update_t rand_update();
    motor_update_t u;
    u.motor = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0, 1: u.throttle = 10'($urandom_range(0, 3));
      2: u.throttle = 10'($urandom_range(1020, 1023));
      default: u.throttle = 10'($urandom);
    endcase
    u.direction = ($urandom_range(0, 7) == 0);
    u.grounded = ($urandom_range(0, 7) == 0);
    u.armed = ($urandom_range(0, 7) != 0);
    u.test_override = ($urandom_range(0, 7) == 0);
    u.aux_test = ($urandom_range(0, 7) == 0);
    u.failsafe = ($urandom_range(0, 3) == 0);
    clock_us += $urandom_range(0, 600000);
    u.now_us = ($urandom_range(0, 15) == 0) ? $urandom : clock_us;
    return u;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < MAX_PRINTED) begin
      $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
    end
    mismatches++;
  endtask

  task automatic send_update(motor_update_t u);
    if (idling_on && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_motor_index <= u.motor;
    in_throttle <= u.throttle;
    in_direction <= u.direction;
    in_grounded <= u.grounded;
    in_armed <= u.armed;
    in_test_override <= u.test_override;
    in_aux_test <= u.aux_test;
    in_failsafe <= u.failsafe;
    in_now_us <= u.now_us;
    do @(posedge clk); while (in_stall);
    queue_line_slots(u);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (slot_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_idle(logic [6:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    idle_setting = v;
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: random stalls, plus a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idling_on && ($urandom_range(0, 99) < 20);
    end
  end

  always @(posedge clk) begin
    line_slot_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (slot_expect_q.size() == 0) begin
        report_mismatch("unexpected slot, frame", 32'(out_frame_word), 32'd0);
      end else begin
        want = slot_expect_q.pop_front();
        if (out_motor !== want.motor) begin
          report_mismatch("motor", 32'(out_motor), 32'(want.motor));
        end
        if (out_frame_word !== want.frame) begin
          report_mismatch("frame_word", 32'(out_frame_word), 32'(want.frame));
        end
        if (out_line_high !== want.line_high) begin
          report_mismatch("line_high", 32'(out_line_high), 32'(want.line_high));
        end
        if (out_last_slot !== want.last_slot) begin
          report_mismatch("last_slot", 32'(out_last_slot), 32'(want.last_slot));
        end
      end
    end
  end

  // failsafe start is 1 out of reset, so the first cutoff is measured from 1
  task automatic test_failsafe_timer();
    send_update(mk_update(2'd0, 10'd512, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 32'd4000001));
    send_update(mk_update(2'd1, 10'd512, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 32'd4000002));
    send_update(mk_update(2'd2, 10'd512, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
    send_update(mk_update(2'd3, 10'd700, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 32'hFFFF_FF00));
    send_update(mk_update(2'd0, 10'd700, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                          32'hFFFF_FF00 + FS_CUTOFF_US));
    send_update(mk_update(2'd1, 10'd700, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                          32'hFFFF_FF01 + FS_CUTOFF_US));
    send_update(mk_update(2'd2, 10'd700, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send_update(mk_update(2'd3, 10'd300, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 32'd0));
    send_update(mk_update(2'd0, 10'd300, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd5));
  endtask

  task automatic test_throttle_map();
    send_update(mk_update(2'd0, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
    send_update(mk_update(2'd1, 10'd1023, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_update(mk_update(2'd2, 10'h2AA, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'hAAAA_AAAA));
    send_update(mk_update(2'd3, 10'h155, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h5555_5555));
    send_update(mk_update(2'd0, 10'd900, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd10));
    send_update(mk_update(2'd1, 10'd900, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd20));
    send_update(mk_update(2'd2, 10'd2, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd30));
    send_update(mk_update(2'd3, 10'd3, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd40));
    send_update(mk_update(2'd0, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 32'd50));
    send_update(mk_update(2'd1, 10'd3, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 32'd60));
  endtask

  task automatic test_idle_setting();
    write_idle(7'd99);
    send_update(mk_update(2'd2, 10'd1023, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
    send_update(mk_update(2'd3, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
    write_idle(7'd127);
    send_update(mk_update(2'd0, 10'd1023, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
    send_update(mk_update(2'd1, 10'd512, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
    write_idle(7'd100);
    send_update(mk_update(2'd2, 10'd1000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
    write_idle(7'd37);
    send_update(mk_update(2'd3, 10'd611, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
    write_idle(7'd0);
  endtask

  task automatic test_output_hold_off();
    hold_left = 500;
    for (int i = 0; i < 8; i++) begin
      send_update(rand_update());
    end
    wait_drained();
  endtask

  task automatic test_random_updates();
    for (int i = 0; i < RANDOM_UPDATES; i++) begin
      if (i % 100 == 99) begin
        write_idle(7'($urandom_range(0, 127)));
      end
      send_update(rand_update());
    end
    write_idle(7'd0);
  endtask

  // mostly reverse requests with no idling, the shared counter keeps climbing
  task automatic test_direction_commands();
    motor_update_t u;
    wait_drained();
    idling_on = 1'b0;
    for (int i = 0; i < 12; i++) begin
      u = rand_update();
      u.direction = (i % 4 != 3);
      send_update(u);
    end
    wait_drained();
    idling_on = 1'b1;
  endtask

  initial begin
    idle_setting = 0;
    last_dir = 1'b0;
    spin_cmd_count = 0;
    failsafe_t0 = 32'd1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_failsafe_timer();
    test_throttle_map();
    test_idle_setting();
    test_output_hold_off();
    test_random_updates();
    test_direction_commands();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && slot_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
